FILE: design/bitmap_first_free_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Bitmap first-free allocator assertion macros
// Shorthand for the clocked, reset-qualified checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/bffa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap first-free allocator package
// Sizes, codes and the bit search shared by the allocator design.
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam int MAX_ENTRIES = 1024;
	localparam int WORD_W      = 32;
	localparam int WORDS       = MAX_ENTRIES / WORD_W;
	localparam int BIT_W       = $clog2(WORD_W);
	localparam int WADDR_W     = $clog2(WORDS);
	localparam int POS_W       = $clog2(MAX_ENTRIES);
	localparam int NUM_W       = POS_W + 1;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = NUM_W;

	localparam logic [NUM_W-1:0] MAX_COUNT = NUM_W'(MAX_ENTRIES);

	localparam logic OP_ALLOC   = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_START = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = CFG_IDX_W'(1);

	typedef struct packed {
		logic             found;
		logic [BIT_W-1:0] index;
	} first_set_t;

	// Lowest set bit of a bitmap word.
	function automatic first_set_t first_set(input logic [WORD_W-1:0] v);
		first_set_t res;
		res = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				res.found = 1'b1;
				res.index = BIT_W'(i);
			end
		end
		return res;
	endfunction

endpackage

FILE: design/bitmap_first_free_allocator_unit.sv
// ----------------------------------------------------------------------------
// Bitmap first-free allocator
// Keeps a used/free bitmap in a word-wide memory, hands out the lowest free
// entry at or above the search start and frees entries on release requests.
// ----------------------------------------------------------------------------
// Channel  | Ports                                | Handshake
// request  | operation, entry_number              | start high while busy low
// result   | status, granted_number               | done strobe, one cycle
// config   | cfg_index, cfg_data                  | cfg_we, no wait
//
// An allocate scans one 32-bit bitmap word per cycle from the memory read port;
// the result strobe comes in the cycle after the last word checked. A release
// reads its word, clears its bit in S_REL and then gives its result; a request
// rejected on its range or count gives its result in the next cycle. Reset clears
// 32 row valid bits at once, with no clearing pass. One request is in work at a
// time and the result strobe cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_unit
	import bffa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  operation,
	input  logic [NUM_W-1:0]      entry_number,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [1:0]            status,
	output logic [NUM_W-1:0]      granted_number
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_ALLOC,
		S_REL
	} state_t;

	state_t              state_q;
	logic [POS_W-1:0]    search_start_q;
	logic [NUM_W-1:0]    entry_count_q;
	logic [WADDR_W-1:0]  word_q;
	logic [BIT_W-1:0]    bit_q;
	logic                done_q;
	logic [1:0]          status_q;
	logic [NUM_W-1:0]    granted_q;

	logic [WORD_W-1:0]   mem [WORDS];
	logic [WORDS-1:0]    row_vld_q;
	logic [WORD_W-1:0]   rd_word_s1;
	logic                rd_vld_s1;

	logic [NUM_W-1:0]    eff_count;
	logic [NUM_W-1:0]    last_num;
	logic [POS_W-1:0]    last_pos;
	logic [NUM_W-1:0]    rel_num;
	logic [POS_W-1:0]    rel_pos;
	logic                start_ok;
	logic                rel_ok;
	logic [WADDR_W-1:0]  rd_addr;
	logic [WORD_W-1:0]   rd_data;
	logic [WORD_W-1:0]   lo_mask;
	logic [WORD_W-1:0]   hi_mask;
	logic [WORD_W-1:0]   free_v;
	first_set_t          hit;
	logic                mem_we;
	logic [WORD_W-1:0]   mem_wd;
	logic                accept;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign eff_count = (entry_count_q > MAX_COUNT) ? MAX_COUNT : entry_count_q;
	assign last_num  = eff_count - NUM_W'(1);
	assign last_pos  = last_num[POS_W-1:0];
	assign rel_num   = entry_number - NUM_W'(1);
	assign rel_pos   = rel_num[POS_W-1:0];
	assign start_ok  = {1'b0, search_start_q} < eff_count;
	assign rel_ok    = (entry_number != '0) && (entry_number <= eff_count);

	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = (operation == OP_RELEASE) ? rel_pos[POS_W-1:BIT_W]
				: search_start_q[POS_W-1:BIT_W];
		end else begin
			rd_addr = word_q + WADDR_W'(1);
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : '0;
	assign lo_mask = (word_q == search_start_q[POS_W-1:BIT_W])
		? ({WORD_W{1'b1}} << search_start_q[BIT_W-1:0]) : {WORD_W{1'b1}};
	assign hi_mask = (word_q == last_pos[POS_W-1:BIT_W])
		? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_pos[BIT_W-1:0]))
		: {WORD_W{1'b1}};
	assign free_v  = ~rd_data & lo_mask & hi_mask;
	assign hit     = first_set(free_v);

	always_comb begin
		mem_we = 1'b0;
		mem_wd = rd_data;
		case (state_q)
			S_ALLOC: begin
				mem_we = hit.found;
				mem_wd = rd_data | (WORD_W'(1) << hit.index);
			end
			S_REL: begin
				mem_we = 1'b1;
				mem_wd = rd_data & ~(WORD_W'(1) << bit_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[word_q] <= mem_wd;
		end
		rd_word_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[word_q] <= 1'b1;
			end
			rd_vld_s1 <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_start_q <= '0;
			entry_count_q  <= MAX_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEARCH_START: search_start_q <= cfg_data[POS_W-1:0];
				CFG_ENTRY_COUNT:  entry_count_q  <= cfg_data;
				default: begin
					entry_count_q <= entry_count_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			word_q    <= '0;
			bit_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_DONE;
			granted_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (operation == OP_ALLOC) begin
							if (start_ok) begin
								word_q  <= search_start_q[POS_W-1:BIT_W];
								state_q <= S_ALLOC;
							end else begin
								done_q    <= 1'b1;
								status_q  <= ST_FULL;
								granted_q <= '0;
							end
						end else begin
							if (rel_ok) begin
								word_q  <= rel_pos[POS_W-1:BIT_W];
								bit_q   <= rel_pos[BIT_W-1:0];
								state_q <= S_REL;
							end else begin
								done_q    <= 1'b1;
								status_q  <= ST_RANGE;
								granted_q <= '0;
							end
						end
					end
				end
				S_ALLOC: begin
					if (hit.found) begin
						done_q    <= 1'b1;
						status_q  <= ST_DONE;
						granted_q <= {1'b0, word_q, hit.index} + NUM_W'(1);
						state_q   <= S_IDLE;
					end else if (word_q == last_pos[POS_W-1:BIT_W]) begin
						done_q    <= 1'b1;
						status_q  <= ST_FULL;
						granted_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						word_q <= word_q + WADDR_W'(1);
					end
				end
				S_REL: begin
					done_q    <= 1'b1;
					status_q  <= ST_DONE;
					granted_q <= '0;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign granted_number = granted_q;

`include "bitmap_first_free_allocator_unit_macros.svh"

	`BFFA_ASSERT_NOW(a_grant_in_window, done && granted_number != '0,
		granted_number > {1'b0, search_start_q} && granted_number <= eff_count,
		"granted entry lies outside the search window")
	`BFFA_ASSERT_NOW(a_fail_no_grant, done && status != ST_DONE,
		granted_number == '0, "failed request reports a granted entry")
	`BFFA_ASSERT_NEXT(a_result_ends_work, busy && (mem_we || state_q == S_REL),
		done && !busy, "completed request gave no result strobe")

endmodule
